/* rtl/core/asue_pkg.sv */
// ----------------------------------------------------------------------------
// asue_pkg
// shared codes and helpers for the attribute store update engine
// ----------------------------------------------------------------------------
package asue_pkg;

  localparam logic [2:0] OP_INC = 3'd0;
  localparam logic [2:0] OP_DEC = 3'd1;
  localparam logic [2:0] OP_ADD = 3'd2;
  localparam logic [2:0] OP_SUB = 3'd3;
  localparam logic [2:0] OP_MUL = 3'd4;
  localparam logic [2:0] OP_DIV = 3'd5;
  localparam logic [2:0] OP_MOD = 3'd6;
  localparam logic [2:0] OP_SET = 3'd7;

  localparam logic [1:0] FN_APPLY = 2'd0;
  localparam logic [1:0] FN_LOAD  = 2'd1;

  localparam logic [1:0] ES_64 = 2'd0;
  localparam logic [1:0] ES_32 = 2'd1;

  localparam logic [1:0] CFG_OP_KIND   = 2'd0;
  localparam logic [1:0] CFG_OP_VALUE  = 2'd1;
  localparam logic [1:0] CFG_ELEM_SIZE = 2'd2;

  // divider request and reply
  typedef struct packed {
    logic        start;
    logic        want_mod;
    logic [63:0] dividend;
    logic [63:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } div_rsp_t;

  function automatic logic [63:0] fit_width(input logic [63:0] v, input logic [1:0] es);
    logic [63:0] r;
    unique case (es)
      ES_64:   r = v;
      ES_32:   r = {{32{v[31]}}, v[31:0]};
      default: r = {{56{v[7]}}, v[7:0]};
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/asue_div.sv */
// ----------------------------------------------------------------------------
// asue_div
// signed 64-bit divider, one quotient bit per cycle, truncating toward zero
// ----------------------------------------------------------------------------
module asue_div
  import asue_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy_r, busy_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] dvs_r, dvs_nxt;
  logic        neg_q_r, neg_q_nxt;
  logic        neg_r_r, neg_r_nxt;
  logic        mod_r, mod_nxt;
  logic        done_r, done_nxt;
  logic [63:0] res_r, res_nxt;
  logic [64:0] trial;
  logic [63:0] shifted;
  logic [63:0] q_fin, r_fin;

  always_comb begin
    busy_nxt  = busy_r;
    cnt_nxt   = cnt_r;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    dvs_nxt   = dvs_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    mod_nxt   = mod_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;
    shifted   = {rem_r[62:0], quo_r[63]};
    trial     = {1'b0, shifted} - {1'b0, dvs_r};
    q_fin     = neg_q_r ? -{quo_r[62:0], ~trial[64]} : {quo_r[62:0], ~trial[64]};
    r_fin     = trial[64] ? shifted : trial[63:0];
    if (neg_r_r) r_fin = -r_fin;
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = 7'd0;
      quo_nxt   = req.dividend[63] ? -req.dividend : req.dividend;
      rem_nxt   = '0;
      dvs_nxt   = req.divisor[63] ? -req.divisor : req.divisor;
      neg_q_nxt = req.dividend[63] ^ req.divisor[63];
      neg_r_nxt = req.dividend[63];
      mod_nxt   = req.want_mod;
    end else if (busy_r) begin
      rem_nxt = trial[64] ? shifted : trial[63:0];
      quo_nxt = {quo_r[62:0], ~trial[64]};
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
        res_nxt  = mod_r ? r_fin : q_fin;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    dvs_r   <= dvs_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
    mod_r   <= mod_nxt;
    res_r   <= res_nxt;
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !req.start) else $error("divider restarted while busy");
  a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held");
  a_done_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider busy at done");

endmodule

/* rtl/core/asue_mul.sv */
// ----------------------------------------------------------------------------
// asue_mul
// 64x64 low-half multiplier from registered 32x32 partial products and an add
// ----------------------------------------------------------------------------
module asue_mul
  import asue_pkg::*;
(
  input  logic        clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll_r;
  logic [31:0] lh_r, hl_r;

  always_ff @(posedge clk) begin
    ll_r <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lh_r <= a[31:0] * b[63:32];
    hl_r <= a[63:32] * b[31:0];
  end

  assign p = ll_r + {lh_r + hl_r, 32'd0};

endmodule

/* rtl/core/attribute_store_update_engine_top.sv */
// ----------------------------------------------------------------------------
// attribute_store_update_engine_top
// per-document integer attribute store with load, read and read-modify-write
// ----------------------------------------------------------------------------
// One item is taken while busy is low and start is high; busy then stays high
// until its result has been shown for one cycle on out_valid, which the
// receiver must take as it comes. Load, read, the add, sub, inc, dec and set
// operations, and div or mod by zero, keep busy high through memory read,
// compute, write back and result strobe, so a new item is taken only after
// the last one's strobe; multiply adds a state because its partial products
// are registered; divide and modulo by a nonzero operand also wait while the
// divider retires one quotient bit a cycle, with a step each to start it and
// to take its result. The store is one synchronous single-port memory of
// NUM_DOCS entries with no reset: entries are defined only once loaded. Items
// to an index at or beyond NUM_DOCS touch nothing and report zero values.
// Configuration must be written only while busy is low; the block does not
// enforce it.
// ----------------------------------------------------------------------------
module attribute_store_update_engine_top
  import asue_pkg::*;
#(
  parameter int NUM_DOCS = 4096
)(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_func,
  input  logic [11:0] in_doc_index,
  input  logic [63:0] in_load_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  output logic        out_valid,
  output logic [11:0] out_index,
  output logic [63:0] out_prior_value,
  output logic [63:0] out_after_value,
  output logic        out_zero_divisor
);

  localparam int AW = (NUM_DOCS > 1) ? $clog2(NUM_DOCS) : 1;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_CALC = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;

  logic [2:0]  op_kind_r;
  logic [63:0] op_value_r;
  logic [1:0]  elem_size_r;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  func_r;
  logic [11:0] idx_r;
  logic [63:0] data_r;
  logic        in_range_r;
  logic [63:0] prior_r, prior_nxt;
  logic [63:0] after_r, after_nxt;
  logic        zdiv_r, zdiv_nxt;
  logic        ov_r;
  logic [63:0] ov_prior_r, ov_after_r;
  logic        ov_zdiv_r;
  logic        in_fire;

  logic [63:0] mem [NUM_DOCS];
  logic [63:0] rd_data_r;
  logic        mem_we;
  logic [AW-1:0] mem_addr;

  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [63:0] mul_p;
  logic [63:0] rd_fit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_kind_r   <= OP_INC;
      op_value_r  <= '0;
      elem_size_r <= ES_64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_OP_KIND:   op_kind_r <= cfg_data[2:0];
        CFG_OP_VALUE:  op_value_r <= cfg_data;
        CFG_ELEM_SIZE: elem_size_r <= cfg_data[1:0];
        default:       ;
      endcase
    end
  end

  // input transfer
  assign in_fire = start && !busy;

  assign mem_addr = AW'(idx_r);
  assign mem_we   = (state_r == S_WB) && in_range_r &&
                    ((func_r == FN_APPLY) || (func_r == FN_LOAD));

  // single port store, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= after_r;
    rd_data_r <= mem[mem_addr];
  end

  assign rd_fit = fit_width(rd_data_r, elem_size_r);

  // partial products taken from the read data during the compute cycle
  asue_mul u_mul (.clk(clk), .a(rd_fit), .b(op_value_r), .p(mul_p));
  asue_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  always_comb begin
    state_nxt       = state_r;
    prior_nxt       = prior_r;
    after_nxt       = after_r;
    zdiv_nxt        = zdiv_r;
    dreq.start      = 1'b0;
    dreq.want_mod   = (op_kind_r == OP_MOD);
    dreq.dividend   = prior_r;
    dreq.divisor    = op_value_r;
    unique case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_READ;
      S_READ: begin
        // memory address presented now; data registered at the end of this cycle
        state_nxt = S_CALC;
      end
      S_CALC: begin
        prior_nxt = in_range_r ? rd_fit : '0;
        after_nxt = prior_nxt;
        zdiv_nxt  = 1'b0;
        state_nxt = S_WB;
        if (in_range_r && func_r == FN_LOAD) begin
          after_nxt = fit_width(data_r, elem_size_r);
        end else if (in_range_r && func_r == FN_APPLY) begin
          unique case (op_kind_r)
            OP_INC: after_nxt = fit_width(rd_fit + 64'd1, elem_size_r);
            OP_DEC: after_nxt = fit_width(rd_fit - 64'd1, elem_size_r);
            OP_ADD: after_nxt = fit_width(rd_fit + op_value_r, elem_size_r);
            OP_SUB: after_nxt = fit_width(rd_fit - op_value_r, elem_size_r);
            OP_MUL: state_nxt = S_MUL;
            OP_DIV, OP_MOD: begin
              if (op_value_r == '0) zdiv_nxt = 1'b1;
              else state_nxt = S_DIV;
            end
            default: after_nxt = fit_width(op_value_r, elem_size_r);
          endcase
        end
      end
      S_MUL: begin
        after_nxt = fit_width(mul_p, elem_size_r);
        state_nxt = S_WB;
      end
      S_DIV: begin
        dreq.start = 1'b0;
        if (drsp.done) begin
          after_nxt = fit_width(drsp.result, elem_size_r);
          state_nxt = S_WB;
        end
      end
      S_WB:    state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // kick the divider in the compute cycle that moves into its wait state
    if (state_r == S_CALC && state_nxt == S_DIV) begin
      dreq.start    = 1'b1;
      dreq.dividend = rd_fit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= (state_r == S_WB);
    end
    if (in_fire) begin
      func_r     <= in_func;
      idx_r      <= in_doc_index;
      data_r     <= in_load_data;
      in_range_r <= ({9'd0, in_doc_index} < 21'(NUM_DOCS));
    end
    prior_r <= prior_nxt;
    after_r <= after_nxt;
    zdiv_r  <= zdiv_nxt;
    if (state_r == S_WB) begin
      ov_prior_r <= prior_r;
      ov_after_r <= after_r;
      ov_zdiv_r  <= zdiv_r;
    end
  end

  // result register: loaded at write back, shown in the cycle after as one strobe
  logic [11:0] ov_idx_r;
  always_ff @(posedge clk) begin
    if (state_r == S_WB) ov_idx_r <= idx_r;
  end

  assign busy             = (state_r != S_IDLE) || ov_r;
  assign out_valid        = ov_r;
  assign out_index        = ov_idx_r;
  assign out_prior_value  = ov_prior_r;
  assign out_after_value  = ov_after_r;
  assign out_zero_divisor = ov_zdiv_r;

  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe held");
  a_wb_then_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB) |=> out_valid) else $error("write back without result");
  a_zdiv_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_zero_divisor && out_valid |-> (op_kind_r == OP_DIV || op_kind_r == OP_MOD))
    else $error("zero divisor flag on wrong op");
  a_zdiv_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_zero_divisor && out_valid |-> out_prior_value == out_after_value)
    else $error("entry changed on zero divisor");

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the attribute store update engine
// ----------------------------------------------------------------------------
// A short directed table covers wrap at the 64-bit limits, division and
// modulo by zero and by -1, element size changes and the unused func and size
// codes. It is followed by random phases, each with its own register setting.
// A local model of the store predicts every result. Entries are applied to or
// read only after they have been loaded. The prior value of a first load is
// undefined and is not compared.
// ----------------------------------------------------------------------------
module tb_top;
  import asue_pkg::*;

  localparam logic [1:0] FN_READ     = 2'd2;
  localparam logic [1:0] FN_READ_ALT = 2'd3;
  localparam logic [1:0] ES_8        = 2'd2;
  localparam logic [1:0] ES_8_ALT    = 2'd3;
  localparam int         DOCS        = 4096;
  localparam int         STALL_LIMIT = 5000;
  localparam logic [63:0] MAX64 = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] MIN64 = 64'h8000_0000_0000_0000;
  localparam logic [63:0] NEG1  = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [11:0] idx;
    logic [63:0] prior;
    logic [63:0] after;
    logic        zdiv;
    bit          prior_known;
  } upd_result_t;

  typedef struct {
    logic [2:0]  kind;
    logic [63:0] operand;
    logic [1:0]  esize;
    logic [1:0]  func;
    logic [11:0] idx;
    logic [63:0] data;
    bit          typed;
    logic [63:0] after;
    logic        zdiv;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_func;
  logic [11:0] in_doc_index;
  logic [63:0] in_load_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [63:0] cfg_data;
  logic        out_valid;
  logic [11:0] out_index;
  logic [63:0] out_prior_value;
  logic [63:0] out_after_value;
  logic        out_zero_divisor;

  // local copy of the store and of the registers
  logic [63:0] doc_value [DOCS];
  bit          doc_loaded [DOCS];
  logic [11:0] loaded_list [$];
  logic [2:0]  cur_kind;
  logic [63:0] cur_operand;
  logic [1:0]  cur_esize;

  upd_result_t pending_updates [$];
  int          error_count;
  int          stall_cycles;
  dir_row_t    dir_tab [21];
  logic [11:0] hot_idx [24];

  attribute_store_update_engine_top #(.NUM_DOCS(DOCS)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_func          (in_func),
    .in_doc_index     (in_doc_index),
    .in_load_data     (in_load_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_index        (out_index),
    .out_prior_value  (out_prior_value),
    .out_after_value  (out_after_value),
    .out_zero_divisor (out_zero_divisor)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // wrap to the element size, unused size codes act as 8 bits
  function automatic logic [63:0] wrap_elem(logic [63:0] v, logic [1:0] es);
    if (es == ES_64) begin
      return v;
    end else if (es == ES_32) begin
      return {{32{v[31]}}, v[31:0]};
    end
    return {{56{v[7]}}, v[7:0]};
  endfunction

  function automatic logic [63:0] abs64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  // works out one update and advances the local store
  function automatic upd_result_t update_store(logic [1:0] func, logic [11:0] idx,
                                              logic [63:0] data);
    upd_result_t res;
    logic [63:0] r;
    logic [63:0] q;
    res.idx         = idx;
    res.zdiv        = 1'b0;
    res.prior_known = doc_loaded[idx];
    res.prior       = wrap_elem(doc_value[idx], cur_esize);
    res.after       = res.prior;
    if (func == FN_LOAD) begin
      res.after = wrap_elem(data, cur_esize);
    end else if (func == FN_APPLY) begin
      r = res.prior;
      case (cur_kind)
        OP_INC: r = res.prior + 64'd1;
        OP_DEC: r = res.prior - 64'd1;
        OP_ADD: r = res.prior + cur_operand;
        OP_SUB: r = res.prior - cur_operand;
        OP_MUL: r = res.prior * cur_operand;
        OP_DIV, OP_MOD: begin
          if (cur_operand == 64'd0) begin
            res.zdiv = 1'b1;
          end else if (cur_kind == OP_DIV) begin
            q = abs64(res.prior) / abs64(cur_operand);
            r = (res.prior[63] ^ cur_operand[63]) ? -q : q;
          end else begin
            q = abs64(res.prior) % abs64(cur_operand);
            r = res.prior[63] ? -q : q;
          end
        end
        default: r = cur_operand;
      endcase
      res.after = wrap_elem(r, cur_esize);
    end
    if (func == FN_LOAD || func == FN_APPLY) begin
      doc_value[idx] = res.after;
      if (!doc_loaded[idx]) begin
        doc_loaded[idx] = 1'b1;
        loaded_list.push_back(idx);
      end
    end
    return res;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return MAX64;
      1: return MIN64;
      2: return 64'($signed($urandom_range(20)) - 10);
      3: return {56'd0, 8'($urandom)};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // registers change only with nothing in flight
  task automatic write_regs(logic [2:0] kind, logic [63:0] operand, logic [1:0] es);
    start <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0 || busy) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_OP_KIND;
    cfg_data  <= {61'd0, kind};
    @(posedge clk);
    cfg_index <= CFG_OP_VALUE;
    cfg_data  <= operand;
    @(posedge clk);
    cfg_index <= CFG_ELEM_SIZE;
    cfg_data  <= {62'd0, es};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_kind    = kind;
    cur_operand = operand;
    cur_esize   = es;
  endtask

  // holds start high until the transfer, then logs the expected update;
  // start is left high so back-to-back items need no second assignment
  task automatic issue_item(logic [1:0] func, logic [11:0] idx, logic [63:0] data,
                            bit typed, logic [63:0] after, logic zdiv);
    upd_result_t res;
    start        <= 1'b1;
    in_func      <= func;
    in_doc_index <= idx;
    in_load_data <= data;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    res = update_store(func, idx, data);
    if (typed) begin
      res.after = after;
      res.zdiv  = zdiv;
    end
    pending_updates.push_back(res);
  endtask

  task automatic sender_gap(int pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // result checking, watchdog
  always @(posedge clk) begin
    upd_result_t exp_res;
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
      if (stall_cycles > STALL_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
      if (out_valid) begin
        if (pending_updates.size() == 0) begin
          $error("result with nothing expected, index %0d", out_index);
          error_count++;
        end else begin
          exp_res = pending_updates.pop_front();
          if (out_index !== exp_res.idx) begin
            $error("out_index exp %h got %h", exp_res.idx, out_index);
            error_count++;
          end
          if (exp_res.prior_known && out_prior_value !== exp_res.prior) begin
            $error("out_prior_value exp %h got %h", exp_res.prior, out_prior_value);
            error_count++;
          end
          if (out_after_value !== exp_res.after) begin
            $error("out_after_value exp %h got %h", exp_res.after, out_after_value);
            error_count++;
          end
          if (out_zero_divisor !== exp_res.zdiv) begin
            $error("out_zero_divisor exp %b got %b", exp_res.zdiv, out_zero_divisor);
            error_count++;
          end
        end
      end
    end
  end

  initial begin
    int pct;
    int pick;
    logic [1:0] func;
    logic [11:0] idx;
    logic [2:0] kind;
    logic [63:0] operand;

    start        = 1'b0;
    in_func      = FN_APPLY;
    in_doc_index = '0;
    in_load_data = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_OP_KIND;
    cfg_data     = '0;
    rst_n        = 1'b0;
    error_count  = 0;
    stall_cycles = 0;
    cur_kind     = OP_INC;
    cur_operand  = '0;
    cur_esize    = ES_64;
    foreach (doc_loaded[i]) begin
      doc_loaded[i] = 1'b0;
      doc_value[i]  = '0;
    end
    foreach (hot_idx[i]) begin
      hot_idx[i] = 12'($urandom);
    end

    // kind, operand, size, func, index, data, typed, after, flag
    dir_tab = '{
      '{OP_INC, 64'd0, ES_64, FN_LOAD,     12'd0,    MAX64, 1, MAX64, 0},
      '{OP_INC, 64'd0, ES_64, FN_APPLY,    12'd0,    64'd0, 1, MIN64, 0},
      '{OP_DEC, 64'd0, ES_64, FN_APPLY,    12'd0,    64'd0, 1, MAX64, 0},
      '{OP_DEC, 64'd0, ES_64, FN_LOAD,     12'd4095, MIN64, 1, MIN64, 0},
      '{OP_DIV, NEG1,  ES_64, FN_APPLY,    12'd4095, 64'd0, 1, MIN64, 0},
      '{OP_MOD, NEG1,  ES_64, FN_APPLY,    12'd4095, 64'd0, 1, 64'd0, 0},
      '{OP_DIV, 64'd0, ES_64, FN_APPLY,    12'd0,    64'd0, 1, MAX64, 1},
      '{OP_MOD, 64'd0, ES_64, FN_APPLY,    12'd0,    64'd0, 1, MAX64, 1},
      '{OP_ADD, 64'd5, ES_64, FN_APPLY,    12'd0,    64'd0, 0, 64'd0, 0},
      '{OP_SUB, MIN64, ES_64, FN_APPLY,    12'd0,    64'd0, 0, 64'd0, 0},
      '{OP_MUL, 64'hFFFF_FFFF_FFFF_FFFD, ES_64, FN_APPLY, 12'd0, 64'd0, 0, 64'd0, 0},
      '{OP_SET, 64'd42, ES_64, FN_APPLY,   12'd0,    64'd0, 1, 64'd42, 0},
      '{OP_SET, MAX64, ES_32, FN_LOAD,     12'hAAA,
        64'h1234_5678_8000_0000, 1, 64'hFFFF_FFFF_8000_0000, 0},
      '{OP_INC, 64'd0, ES_8,  FN_LOAD,     12'h555,  64'h7F, 1, 64'h7F, 0},
      '{OP_INC, 64'd0, ES_8,  FN_APPLY,    12'h555,  64'd0, 1, 64'hFFFF_FFFF_FFFF_FF80, 0},
      '{OP_DIV, 64'd7, ES_8_ALT, FN_APPLY, 12'h555,  64'd0, 0, 64'd0, 0},
      '{OP_MOD, 64'hFFFF_FFFF_FFFF_FFFB, ES_8_ALT, FN_APPLY, 12'h555, 64'd0, 0, 64'd0, 0},
      '{OP_MUL, MAX64, ES_32, FN_READ,     12'd0,    64'd0, 1, 64'd42, 0},
      '{OP_MUL, MAX64, ES_32, FN_READ_ALT, 12'd4095, 64'd0, 1, 64'd0, 0},
      '{OP_SET, MIN64, ES_64, FN_APPLY,    12'hAAA,  64'd0, 1, MIN64, 0},
      '{OP_SET, MIN64, ES_64, FN_LOAD,     12'hAAA,  NEG1,  1, NEG1, 0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table, registers rewritten whenever the row asks for a change
    write_regs(dir_tab[0].kind, dir_tab[0].operand, dir_tab[0].esize);
    foreach (dir_tab[r]) begin
      if (dir_tab[r].kind != cur_kind || dir_tab[r].operand != cur_operand ||
          dir_tab[r].esize != cur_esize) begin
        write_regs(dir_tab[r].kind, dir_tab[r].operand, dir_tab[r].esize);
      end
      issue_item(dir_tab[r].func, dir_tab[r].idx, dir_tab[r].data,
                 dir_tab[r].typed, dir_tab[r].after, dir_tab[r].zdiv);
    end

    // random phases: sender idles about a third of the time, then about
    // three in five, then never
    for (int ph = 0; ph < 30; ph++) begin
      pct = (ph < 10) ? 34 : (ph < 20) ? 61 : 0;
      kind = 3'(ph);
      if (ph >= 8) begin
        kind = 3'($urandom_range(7));
      end
      operand = rand_word();
      if ((kind == OP_DIV || kind == OP_MOD) && $urandom_range(3) == 0) begin
        operand = 64'd0;
      end
      write_regs(kind, operand, 2'($urandom_range(3)));
      for (int n = 0; n < 60; n++) begin
        pick = $urandom_range(99);
        if (loaded_list.size() == 0 || pick < 30) begin
          func = FN_LOAD;
          idx  = ($urandom_range(99) < 70) ? hot_idx[$urandom_range(23)] : 12'($urandom);
        end else begin
          func = (pick < 75) ? FN_APPLY : (pick < 92) ? FN_READ : FN_READ_ALT;
          idx  = loaded_list[$urandom_range(loaded_list.size() - 1)];
        end
        issue_item(func, idx, rand_word(), 0, 64'd0, 1'b0);
        sender_gap(pct);
      end
    end

    // drain, then a margin for the slowest operation
    start <= 1'b0;
    while (pending_updates.size() != 0) begin
      @(posedge clk);
    end
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
